/* rtl/core/bpc_pkg.sv */
package bpc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temperature_decidegc;
        logic signed [31:0] pressure_pa;
        logic               div_error;
    } t_res;

    typedef struct packed {
        logic [15:0] ut;
        logic [23:0] up;
    } t_job;

    typedef struct packed {
        logic [1:0]  oss;
        logic [47:0] ac123;
        logic [47:0] ac456;
        logic [31:0] b12;
        logic [31:0] mcmd;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_TX1, S_TD, S_TDS, S_TDIV, S_B6, S_SQ, S_P1, S_P2, S_B3A, S_B3,
        S_P4, S_X3, S_B4, S_B7, S_PDS, S_PDIV, S_Q1, S_Q2, S_Q3, S_FIN, S_DONE
    } t_bstate;

    localparam logic [2:0] REG_OSS   = 3'd0;
    localparam logic [2:0] REG_AC123 = 3'd1;
    localparam logic [2:0] REG_AC456 = 3'd2;
    localparam logic [2:0] REG_B12   = 3'd3;
    localparam logic [2:0] REG_MCMD  = 3'd4;

    localparam logic [31:0] K_4000  = 32'd4000;
    localparam logic [31:0] K_32768 = 32'd32768;
    localparam logic [31:0] K_50000 = 32'd50000;
    localparam logic [31:0] K_3038  = 32'd3038;
    localparam logic [31:0] K_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] K_3791  = 32'd3791;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* rtl/core/baro_temp_pressure_compensation_unit.sv */
// Barometer compensation: raw temperature and pressure word in, 0.1 degC and Pa out.
// The back end works on one word at a time: two shift-subtract divisions plus the
// sequencer steps on one shared multiplier; a two-entry queue and the output
// register let the front take words while the back computes or a result waits.
// Reset (synchronous, active low) clears handshake state and all calibration to zero.
module baro_temp_pressure_compensation_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bpc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bpc_pkg::t_res o_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [47:0]   i_cfg_wdata
);
    import bpc_pkg::*;

    t_cfg r_cfg;
    logic w_push, w_qready, w_qvalid, w_pop;
    t_job w_fjob, w_qjob;

    // calibration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_OSS:   r_cfg.oss   <= i_cfg_wdata[1:0];
                REG_AC123: r_cfg.ac123 <= i_cfg_wdata;
                REG_AC456: r_cfg.ac456 <= i_cfg_wdata;
                REG_B12:   r_cfg.b12   <= i_cfg_wdata[31:0];
                REG_MCMD:  r_cfg.mcmd  <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // front: accept the word, align raw pressure
    bpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_oss     (r_cfg.oss),
        .o_push    (w_push),
        .o_job     (w_fjob),
        .i_q_ready (w_qready)
    );

    // hold pending words between front and back
    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_ready (w_qready),
        .o_valid (w_qvalid),
        .o_job   (w_qjob),
        .i_pop   (w_pop)
    );

    // back: sequence the compensation math and register the result
    bpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_qvalid),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );
endmodule

/* rtl/core/bpc_front.sv */
module bpc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bpc_pkg::t_in  i_data,
    input  logic [1:0]    i_oss,
    output logic          o_push,
    output bpc_pkg::t_job o_job,
    input  logic          i_q_ready
);
    import bpc_pkg::*;

    logic r_valid, n_valid;
    t_job r_job;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_q_ready) n_valid = 1'b0;
        if (i_valid && o_ready)   n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            // align raw pressure to the oversampling setting
            r_job.ut <= i_data.raw_temperature;
            r_job.up <= i_data.raw_pressure >> (4'd8 - {2'b00, i_oss});
        end
    end
endmodule

/* rtl/core/bpc_queue.sv */
module bpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpc_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output bpc_pkg::t_job o_job,
    input  logic          i_pop
);
    import bpc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* rtl/core/bpc_div.sv */
module bpc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_signed,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    logic        r_busy, r_done, r_neg;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_den;
    logic [32:0] w_sh, w_diff;
    logic        w_nn, w_dn;

    assign w_nn   = i_signed && i_num[31];
    assign w_dn   = i_signed && i_den[31];
    assign w_sh   = {r_rem, r_quo[31]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0);
            if (i_start)                      r_busy <= 1'b1;
            else if (r_busy && r_cnt == 5'd0) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= w_nn ? (32'd0 - i_num) : i_num;
            r_den <= w_dn ? (32'd0 - i_den) : i_den;
            r_neg <= w_nn ^ w_dn;
            r_cnt <= 5'd31;
        end else if (r_busy) begin
            // one restoring step per cycle
            r_rem <= w_diff[32] ? w_sh[31:0] : w_diff[31:0];
            r_quo <= {r_quo[30:0], !w_diff[32]};
            r_cnt <= r_cnt - 5'd1;
        end
    end
endmodule

/* rtl/core/bpc_back.sv */
module bpc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpc_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  bpc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output bpc_pkg::t_res o_data
);
    import bpc_pkg::*;

    t_bstate r_st, n_st;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] r_ut, r_up, r_x1, r_x2, r_x3, r_d, r_b5, r_b6, r_sq, r_b3, r_upb3;
    logic [31:0] r_b4, r_b7, r_p;
    logic        r_err, r_ovalid;
    t_res        r_out;
    logic [31:0] w_ma, w_mb, w_prod, w_quo, w_dnum, w_dden, w_ts, w_t8;
    logic        w_dstart, w_dsig, w_ddone, w_load;
    logic [15:0] w_temp;

    assign ac1 = sx16(i_cfg.ac123[47:32]);
    assign ac2 = sx16(i_cfg.ac123[31:16]);
    assign ac3 = sx16(i_cfg.ac123[15:0]);
    assign ac4 = {16'd0, i_cfg.ac456[47:32]};
    assign ac5 = {16'd0, i_cfg.ac456[31:16]};
    assign ac6 = {16'd0, i_cfg.ac456[15:0]};
    assign b1  = sx16(i_cfg.b12[31:16]);
    assign b2  = sx16(i_cfg.b12[15:0]);
    assign mc  = sx16(i_cfg.mcmd[31:16]);
    assign md  = sx16(i_cfg.mcmd[15:0]);

    assign w_prod = w_ma * w_mb;
    assign w_t8   = 32'($signed(r_p) >>> 8);
    assign w_ts   = 32'($signed(r_b5 + 32'd8) >>> 4);
    assign w_load = (r_st == S_DONE) && (!r_ovalid || i_ready);

    always_comb begin
        if ($signed(w_ts) > $signed(32'd32767))        w_temp = 16'h7FFF;
        else if ($signed(w_ts) < $signed(32'hFFFF8000)) w_temp = 16'h8000;
        else                                            w_temp = w_ts[15:0];
    end

    bpc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dstart),
        .i_signed (w_dsig),
        .i_num    (w_dnum),
        .i_den    (w_dden),
        .o_done   (w_ddone),
        .o_quo    (w_quo)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_q_valid) n_st = S_TX1;
            S_TX1:  n_st = S_TD;
            S_TD:   n_st = S_TDS;
            S_TDS:  n_st = (r_d == 32'd0) ? S_DONE : S_TDIV;
            S_TDIV: if (w_ddone) n_st = S_B6;
            S_B6:   n_st = S_SQ;
            S_SQ:   n_st = S_P1;
            S_P1:   n_st = S_P2;
            S_P2:   n_st = S_B3A;
            S_B3A:  n_st = S_B3;
            S_B3:   n_st = S_P4;
            S_P4:   n_st = S_X3;
            S_X3:   n_st = S_B4;
            S_B4:   n_st = S_B7;
            S_B7:   n_st = (r_b4 == 32'd0) ? S_DONE : S_PDS;
            S_PDS:  n_st = S_PDIV;
            S_PDIV: if (w_ddone) n_st = S_Q1;
            S_Q1:   n_st = S_Q2;
            S_Q2:   n_st = S_Q3;
            S_Q3:   n_st = S_FIN;
            S_FIN:  n_st = S_DONE;
            S_DONE: if (w_load) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // outputs: multiplier operands, divider control and queue pop
    always_comb begin
        w_ma     = 32'd0;
        w_mb     = 32'd0;
        w_dstart = 1'b0;
        w_dsig   = 1'b0;
        w_dnum   = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
        w_dden   = r_b4;
        o_pop    = (r_st == S_IDLE) && i_q_valid;
        case (r_st)
            S_TX1: begin w_ma = r_ut - ac6; w_mb = ac5; end
            S_TDS: begin
                w_dstart = (r_d != 32'd0);
                w_dsig   = 1'b1;
                w_dnum   = {mc[20:0], 11'd0};
                w_dden   = r_d;
            end
            S_SQ:  begin w_ma = r_b6; w_mb = r_b6; end
            S_P1:  begin w_ma = b2;   w_mb = r_sq; end
            S_P2:  begin w_ma = ac2;  w_mb = r_b6; end
            S_B3:  begin w_ma = ac3;  w_mb = r_b6; end
            S_P4:  begin w_ma = b1;   w_mb = r_sq; end
            S_B4:  begin w_ma = ac4;  w_mb = r_x3; end
            S_B7:  begin w_ma = r_upb3; w_mb = K_50000 >> i_cfg.oss; end
            S_PDS: w_dstart = 1'b1;
            S_Q1:  begin w_ma = w_t8; w_mb = w_t8; end
            S_Q2:  begin w_ma = r_x1; w_mb = K_3038; end
            S_Q3:  begin w_ma = K_M7357; w_mb = r_p; end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load)       r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                r_ut  <= {16'd0, i_job.ut};
                r_up  <= {8'd0, i_job.up};
                r_err <= 1'b0;
            end
            S_TX1:  r_x1 <= 32'($signed(w_prod) >>> 15);
            S_TD:   r_d  <= r_x1 + md;
            S_TDS:  if (r_d == 32'd0) r_err <= 1'b1;
            S_TDIV: if (w_ddone) r_b5 <= r_x1 + w_quo;
            S_B6:   r_b6 <= r_b5 - K_4000;
            S_SQ:   r_sq <= 32'($signed(w_prod) >>> 12);
            S_P1:   r_x1 <= 32'($signed(w_prod) >>> 11);
            S_P2:   r_x2 <= 32'($signed(w_prod) >>> 11);
            S_B3A:  r_x3 <= r_x1 + r_x2;
            S_B3: begin
                r_b3 <= 32'($signed((({ac1[29:0], 2'b00} + r_x3) << i_cfg.oss) + 32'd2)
                            >>> 2);
                r_x1 <= 32'($signed(w_prod) >>> 13);
            end
            S_P4: begin
                r_upb3 <= r_up - r_b3;
                r_x2   <= 32'($signed(w_prod) >>> 16);
            end
            S_X3:   r_x3 <= 32'($signed(r_x1 + r_x2 + 32'd2) >>> 2) + K_32768;
            S_B4:   r_b4 <= w_prod >> 15;
            S_B7: begin
                if (r_b4 == 32'd0) r_err <= 1'b1;
                r_b7 <= w_prod;
            end
            S_PDIV: if (w_ddone) r_p <= r_b7[31] ? {w_quo[30:0], 1'b0} : w_quo;
            S_Q1:   r_x1 <= w_prod;
            S_Q2:   r_x1 <= 32'($signed(w_prod) >>> 16);
            S_Q3:   r_x2 <= 32'($signed(w_prod) >>> 16);
            S_FIN:  r_p  <= r_p + 32'($signed(r_x1 + r_x2 + K_3791) >>> 4);
            default: ;
        endcase
        if (w_load) begin
            r_out.temperature_decidegc <= r_err ? 16'sd0 : $signed(w_temp);
            r_out.pressure_pa          <= r_err ? 32'sd0 : $signed(r_p);
            r_out.div_error            <= r_err;
        end
    end
endmodule
